>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition a implies condition c in the same cycle.
`define ASSERT_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Condition a implies condition c in the next cycle.
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)

`endif

`endif

>>> hw/rtl/tbp_pkg.sv
// ----------------------------------------------------------------------------
// tbp_pkg
// Types, constants and counter helpers shared by the predictor modules.
// ----------------------------------------------------------------------------
package tbp_pkg;

  localparam int PC_W        = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [PC_W-1:0] PC_STEP        = 64'd4;
  localparam logic [PC_W-1:0] ENTRY_INIT_TAG = 64'd2;
  localparam logic [1:0]      CNT_INIT       = 2'd2;
  localparam logic [1:0]      CNT_WEAK_TAKEN = 2'd2;
  localparam logic [1:0]      CNT_WEAK_NOT   = 2'd1;
  localparam logic [1:0]      CNT_MAX        = 2'd3;
  localparam logic [1:0]      CNT_MIN        = 2'd0;

  localparam logic OP_RESOLVE = 1'b1;

  // Classified transaction handed from the front to the back.
  typedef struct packed {
    logic            resolve;
    logic            taken;
    logic [PC_W-1:0] pc;
  } item_t;

  // One table entry.
  typedef struct packed {
    logic [PC_W-1:0] tag;
    logic [1:0]      count;
  } entry_t;

  // Queue fill status seen by the front.
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_APPLY
  } bk_state_t;

  function automatic logic [1:0] sat_up(input logic [1:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + 2'd1;
  endfunction

  function automatic logic [1:0] sat_down(input logic [1:0] c);
    return (c == CNT_MIN) ? CNT_MIN : c - 2'd1;
  endfunction

endpackage

>>> hw/rtl/tournament_branch_predictor.sv
// Path: an accepted transaction is written to a queue slot, popped into the read registers (cur,
//   rd_entry) and then loaded into the result register once that register is free. The back
//   takes one transaction at a time: registered table read on pop, then table write and result load.
// Reset: synchronous, active high. The table is then swept slot by slot to its initial value,
//   during which in_stall stays high.
// ----------------------------------------------------------------------------
// tournament_branch_predictor
// Local tagged table plus global counter, arbitrated by a two-bit chooser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tournament_branch_predictor #(
  parameter int TABLE_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [63:0] branch_pc,
  input  logic [63:0] target_pc,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        taken_guess,
  output logic        guess_right
);
  import tbp_pkg::*;

  logic    push;
  logic    pop;
  logic    clearing;
  item_t   push_item;
  item_t   head;
  q_stat_t q_stat;

  // Front: accept a transaction, work out whether the branch was taken
  // (next pc differs from pc plus one instruction) and push it.
  tbp_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .branch_pc (branch_pc),
    .target_pc (target_pc),
    .clearing  (clearing),
    .q_stat    (q_stat),
    .push      (push),
    .item      (push_item)
  );

  // Queue: decouple acceptance from table access so the front keeps taking
  // transactions while a result waits at the output.
  tbp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // Back: read the entry, predict, train the counters and the chooser on a
  // resolve, and hold the result until the consumer takes it.
  tbp_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_stat.nonempty),
    .q_item      (head),
    .q_pop       (pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .taken_guess (taken_guess),
    .guess_right (guess_right)
  );

  // No transaction gets in while the table is being swept.
  `ASSERT_SAME(a_stall_in_clear, clk, rst, clearing, in_stall)
  // A full queue always holds off the front.
  `ASSERT_SAME(a_stall_when_full, clk, rst, q_stat.full, in_stall && !push)
  // The sweep ends with nothing queued.
  `ASSERT_SAME(a_clear_ends_empty, clk, rst, $fell(clearing), !q_stat.nonempty)
  // A pop is never followed on the next cycle by another pop or by a sweep.
  `ASSERT_NEXT(a_pop_not_clearing, clk, rst, pop, !clearing && !pop)

endmodule

>>> hw/rtl/tbp_front.sv
// ----------------------------------------------------------------------------
// tbp_front
// Accept branch transactions, classify outcome, push into the queue.
// ----------------------------------------------------------------------------
module tbp_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  logic [63:0]           branch_pc,
  input  logic [63:0]           target_pc,
  input  logic                  clearing,
  input  tbp_pkg::q_stat_t      q_stat,
  output logic                  push,
  output tbp_pkg::item_t        item
);
  import tbp_pkg::*;

  // Hold off while the table is swept or the queue has no room.
  assign in_stall = clearing | q_stat.full;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    item.resolve = (opcode == OP_RESOLVE);
    item.taken   = (target_pc != (branch_pc + PC_STEP));
    item.pc      = branch_pc;
  end

endmodule

>>> hw/rtl/tbp_queue.sv
// ----------------------------------------------------------------------------
// tbp_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module tbp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tbp_pkg::item_t   push_item,
  input  logic             pop,
  output tbp_pkg::item_t   head,
  output tbp_pkg::q_stat_t stat
);
  import tbp_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  assign head          = slots[rd_ptr];
  assign stat.full     = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.nonempty = (fill != '0);

endmodule

>>> hw/rtl/tbp_back.sv
// ----------------------------------------------------------------------------
// tbp_back
// Table read-modify-write, global counter, chooser and result register.
// ----------------------------------------------------------------------------
module tbp_back #(
  parameter int TABLE_SLOTS = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  tbp_pkg::item_t q_item,
  output logic           q_pop,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           taken_guess,
  output logic           guess_right
);
  import tbp_pkg::*;

  localparam int               IDX_W    = $clog2(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

  bk_state_t        state, state_next;
  logic [IDX_W-1:0] clr_idx;
  item_t            cur;
  entry_t           rd_entry;
  logic [1:0]       shared_count;
  logic [1:0]       chooser;

  entry_t           table_mem [TABLE_SLOTS];

  logic             fire;
  logic             mem_we;
  logic [IDX_W-1:0] wr_idx;
  entry_t           wr_entry;
  logic [IDX_W-1:0] head_idx;
  logic [IDX_W-1:0] cur_idx;
  logic             local_g;
  logic             shared_g;
  logic             guess;
  logic [1:0]       entry_count_next;

  assign head_idx = q_item.pc[IDX_W-1:0] & LAST_IDX;
  assign cur_idx  = cur.pc[IDX_W-1:0] & LAST_IDX;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_idx == LAST_IDX) state_next = ST_IDLE;
      ST_IDLE:  if (q_valid) state_next = ST_APPLY;
      ST_APPLY: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // State outputs.
  always_comb begin
    clearing = 1'b0;
    q_pop    = 1'b0;
    fire     = 1'b0;
    unique case (state)
      ST_CLEAR: clearing = 1'b1;
      ST_IDLE:  q_pop    = q_valid;
      ST_APPLY: fire     = !out_valid || !out_stall;
      default:  clearing = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr_idx <= clr_idx + 1'b1;
    end
  end

  // Prediction and next entry counter from the entry read at pop time.
  always_comb begin
    local_g  = (rd_entry.tag == cur.pc) && rd_entry.count[1];
    shared_g = shared_count[1];
    if (local_g == shared_g) guess = local_g;
    else                     guess = chooser[1] ? shared_g : local_g;

    if (rd_entry.tag != cur.pc) begin
      entry_count_next = cur.taken ? CNT_WEAK_TAKEN : CNT_WEAK_NOT;
    end else begin
      entry_count_next = cur.taken ? sat_up(rd_entry.count) : sat_down(rd_entry.count);
    end
  end

  // Write port: sweep during clear, training on resolve.
  always_comb begin
    mem_we = clearing || (fire && cur.resolve);
    if (clearing) begin
      wr_idx         = clr_idx;
      wr_entry.tag   = ENTRY_INIT_TAG;
      wr_entry.count = CNT_INIT;
    end else begin
      wr_idx         = cur_idx;
      wr_entry.tag   = cur.pc;
      wr_entry.count = entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) table_mem[wr_idx] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_entry <= table_mem[head_idx];
      cur      <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shared_count <= CNT_INIT;
      chooser      <= CNT_INIT;
    end else if (fire && cur.resolve) begin
      shared_count <= cur.taken ? sat_up(shared_count) : sat_down(shared_count);
      if (local_g != shared_g) begin
        chooser <= (shared_g == cur.taken) ? sat_up(chooser) : sat_down(chooser);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      taken_guess <= guess;
      guess_right <= cur.resolve && (guess == cur.taken);
    end
  end

endmodule
